// ----- rtl/tls_pkg.sv -----
`timescale 1ns / 1ps

package tls_pkg;

	localparam int KEY_W = 32;
	localparam int CMD_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_LIN  = 2'd1,
		CMD_BIN  = 2'd2
	} cmd_t;

	typedef logic signed [KEY_W-1:0] key_t;

endpackage

// ----- rtl/tls_if.sv -----
`timescale 1ns / 1ps

interface tls_req_if import tls_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic signed [KEY_W-1:0] value;
	logic                 first;

	modport source (output valid, cmd, value, first, input ready);
	modport sink (input valid, cmd, value, first, output ready);
endinterface

interface tls_rsp_if #(
	parameter int PW = 11
) ();
	logic          valid;
	logic          ready;
	logic          found;
	logic [PW-1:0] position;

	modport source (output valid, found, position, input ready);
	modport sink (input valid, found, position, output ready);
endinterface

// ----- rtl/table_linear_and_binary_search.sv -----
`timescale 1ns / 1ps
// Load: words are accepted back to back while idle.
// Linear search: one table read per cycle from the single RAM port.
// Binary search: each probe is a read (S_BRD), then a compare (S_BCMP); floor(log2(count)) + 1 probes
// at most; a search also waits while the output is held.
// Results sit in an output register; a load may be taken while a result waits.
// Reset clears the entry count and control state; table contents stay undefined, no clear pass.
module table_linear_and_binary_search
	import tls_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	tls_req_if.sink    req,
	tls_rsp_if.source  rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int BW = CW + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LIN,
		S_BRD,
		S_BCMP,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	key_t            key_q;
	logic [CW-1:0]   iss_q;
	logic            rv_s1;
	logic [CW-1:0]   pos_s1;
	logic [BW-1:0]   lo_q;
	logic [BW-1:0]   hi_q;
	logic [BW-1:0]   mid_q;
	logic [CW-1:0]   res_q;
	logic            out_valid_q;
	logic            out_found_q;
	logic [CW-1:0]   out_pos_q;

	key_t            mem [DEPTH];
	key_t            rdata_s1;

	logic            accept;
	logic [CW-1:0]   n_load;
	logic            wr_en;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic [BW:0]     bin_sum;
	logic [BW-1:0]   mid;
	logic [BW-1:0]   mid_m1;
	logic            lin_more;
	logic            out_free;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign n_load   = req.first ? '0 : cnt_q;
	assign wr_en    = accept && (req.cmd == CMD_LOAD) && (n_load < CW'(DEPTH));
	assign bin_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = bin_sum[BW:1];
	assign mid_m1   = mid - BW'(1);
	assign lin_more = (iss_q < cnt_q);
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = iss_q[AW-1:0];
		unique case (state_q)
			S_LIN: begin
				rd_en = lin_more;
			end
			S_BRD: begin
				rd_en   = (lo_q <= hi_q);
				rd_addr = mid_m1[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[n_load[AW-1:0]] <= req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			key_q       <= '0;
			iss_q       <= '0;
			rv_s1       <= 1'b0;
			pos_s1      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_pos_q   <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			rv_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= req.value;
						unique case (req.cmd)
							CMD_LOAD: begin
								cnt_q <= wr_en ? n_load + CW'(1) : n_load;
							end
							CMD_LIN: begin
								iss_q   <= '0;
								state_q <= S_LIN;
							end
							CMD_BIN: begin
								lo_q    <= BW'(1);
								hi_q    <= BW'(cnt_q);
								state_q <= S_BRD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LIN: begin
					if (rv_s1 && (rdata_s1 == key_q)) begin
						res_q   <= pos_s1;
						state_q <= S_DONE;
					end else if (!lin_more && !rv_s1) begin
						res_q   <= '0;
						state_q <= S_DONE;
					end else if (lin_more) begin
						rv_s1  <= 1'b1;
						pos_s1 <= iss_q + CW'(1);
						iss_q  <= iss_q + CW'(1);
					end
				end
				S_BRD: begin
					if (lo_q <= hi_q) begin
						mid_q   <= mid;
						state_q <= S_BCMP;
					end else begin
						res_q   <= '0;
						state_q <= S_DONE;
					end
				end
				S_BCMP: begin
					priority if (key_q == rdata_s1) begin
						res_q   <= mid_q[CW-1:0];
						state_q <= S_DONE;
					end else if (key_q < rdata_s1) begin
						if (mid_q <= BW'(1)) begin
							res_q   <= '0;
							state_q <= S_DONE;
						end else begin
							hi_q    <= mid_q - BW'(1);
							state_q <= S_BRD;
						end
					end else begin
						lo_q    <= mid_q + BW'(1);
						state_q <= S_BRD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= (res_q != '0);
						out_pos_q   <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.found    = out_found_q;
	assign rsp.position = out_pos_q;

	// a reported match always carries a nonzero position, a miss carries zero
	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.found == (rsp.position != '0)))
		else $error("found flag disagrees with position");

	// binary probes stay inside the loaded part of the table
	a_bin_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BRD && rd_en) |-> (BW'(rd_addr) < BW'(cnt_q)))
		else $error("binary probe beyond entry count");

	// linear compare only ever looks at loaded entries
	a_lin_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIN && rv_s1) |-> (pos_s1 <= cnt_q && pos_s1 != '0))
		else $error("linear compare outside table");

	// a finished search hands its word to the output register once there is room
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("search result not delivered");

	// no search result may overwrite a word still waiting on the output
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> out_valid_q)
		else $error("pending result dropped");

endmodule
